// ===== rtl/ipalu_pkg.sv =====
// Package: shared types and constants for the IP address ALU.
`default_nettype none
package ipalu_pkg;
	localparam int AddrW     = 128;
	localparam int DivW      = 32;
	localparam int DivBits   = 4;
	localparam int DivStages = AddrW / DivBits;
	localparam logic [DivW-1:0] Sat32 = '1;

	typedef enum logic [2:0] {
		K_CMP   = 3'd0,
		K_ADDO  = 3'd1,
		K_SUBO  = 3'd2,
		K_ADDA  = 3'd3,
		K_DIST  = 3'd4,
		K_COUNT = 3'd5,
		K_MOD   = 3'd6,
		K_WIDEN = 3'd7
	} kind_t;

	typedef struct packed {
		kind_t              kind;
		logic               av6;
		logic               bv6;
		logic [AddrW-1:0]   a;
		logic [AddrW-1:0]   b;
		logic [63:0]        b_raw;
	} item_t;

	typedef struct packed {
		kind_t              kind;
		logic               av6;
		logic               bv6;
		logic [AddrW-1:0]   a;
		logic               eq;
		logic               lt;
		logic [AddrW-1:0]   off_sum;
		logic [AddrW-1:0]   addr_sum;
		logic [AddrW-1:0]   d_ab;
		logic [AddrW-1:0]   d_ba;
		logic               dzero;
	} mid_t;

	typedef struct packed {
		logic [63:0]        rh;
		logic [63:0]        rl;
		logic               rv6;
		logic               eq;
		logic               lt;
		logic               gt;
		logic [DivW-1:0]    val;
		logic               err;
		logic               is_mod;
	} res_t;

	typedef struct packed {
		logic [DivW-1:0]    rem;
		logic [AddrW-1:0]   num;
		logic [DivW-1:0]    d;
	} div_t;
endpackage
`default_nettype wire

// ===== rtl/ipalu_arith.sv =====
// Two-stage datapath for compare, add, distance, count and widen; also marks modulo items and flags a zero divisor.
`default_nettype none
module ipalu_arith (
	input  wire logic            clk,
	input  wire logic            en,
	input  ipalu_pkg::item_t     item,
	output ipalu_pkg::res_t      res
);
	import ipalu_pkg::*;

	mid_t mid_s2;
	res_t res_s3;
	logic [AddrW-1:0] off_ext;
	mid_t mid_d;
	res_t res_d;
	logic [AddrW-1:0] dist_sel;

	always_comb begin
		off_ext         = {{(AddrW-64){item.b_raw[63]}}, item.b_raw};
		mid_d.kind      = item.kind;
		mid_d.av6       = item.av6;
		mid_d.bv6       = item.bv6;
		mid_d.a         = item.a;
		mid_d.eq        = (item.a == item.b);
		mid_d.lt        = (item.a < item.b);
		mid_d.off_sum   = (item.kind == K_SUBO) ? item.a - off_ext : item.a + off_ext;
		mid_d.addr_sum  = item.a + item.b;
		mid_d.d_ab      = item.a - item.b;
		mid_d.d_ba      = item.b - item.a;
		mid_d.dzero     = (item.b_raw[DivW-1:0] == '0);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mid_s2 <= mid_d;
		end
	end

	always_comb begin
		dist_sel = mid_s2.lt ? mid_s2.d_ba : mid_s2.d_ab;
		res_d = '0;
		res_d.rv6 = mid_s2.av6;
		case (mid_s2.kind)
			K_CMP: begin
				if (mid_s2.av6 != mid_s2.bv6) begin
					res_d.lt = !mid_s2.av6;
					res_d.gt = mid_s2.av6;
				end else begin
					res_d.eq = mid_s2.eq;
					res_d.lt = mid_s2.lt;
					res_d.gt = !mid_s2.eq && !mid_s2.lt;
				end
			end
			K_ADDO, K_SUBO: begin
				if (mid_s2.av6) begin
					{res_d.rh, res_d.rl} = mid_s2.off_sum;
				end else begin
					res_d.rl = {32'd0, mid_s2.off_sum[31:0]};
				end
			end
			K_ADDA: begin
				if (mid_s2.av6 != mid_s2.bv6) begin
					res_d.err = 1'b1;
				end else if (mid_s2.av6) begin
					{res_d.rh, res_d.rl} = mid_s2.addr_sum;
				end else begin
					res_d.rl = {32'd0, mid_s2.addr_sum[31:0]};
				end
			end
			K_DIST, K_COUNT: begin
				if (mid_s2.av6 != mid_s2.bv6) begin
					res_d.err = 1'b1;
				end else if (dist_sel[AddrW-1:DivW] != '0) begin
					res_d.val = Sat32;
				end else if (mid_s2.kind == K_COUNT && dist_sel[DivW-1:0] != Sat32) begin
					res_d.val = dist_sel[DivW-1:0] + 1'b1;
				end else begin
					res_d.val = dist_sel[DivW-1:0];
				end
			end
			K_MOD: begin
				res_d.is_mod = 1'b1;
				res_d.err    = mid_s2.dzero;
			end
			default: begin
				{res_d.rh, res_d.rl} = mid_s2.a;
				res_d.rv6 = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_s3 <= res_d;
		end
	end

	assign res = res_s3;
endmodule
`default_nettype wire

// ===== rtl/ipalu_div_stage.sv =====
// One remainder stage: consumes DivBits dividend bits per cycle while en is high.
`default_nettype none
module ipalu_div_stage (
	input  wire logic           clk,
	input  wire logic           en,
	input  ipalu_pkg::div_t     din,
	output ipalu_pkg::div_t     dout
);
	import ipalu_pkg::*;

	div_t             nxt;
	div_t             stage_q;
	logic [DivW:0]    t;

	always_comb begin
		nxt = din;
		t   = '0;
		for (int i = 0; i < DivBits; i++) begin
			t = {nxt.rem, nxt.num[AddrW-1]};
			if (t >= {1'b0, nxt.d}) begin
				t = t - {1'b0, nxt.d};
			end
			nxt.rem = t[DivW-1:0];
			nxt.num = {nxt.num[AddrW-2:0], 1'b0};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			stage_q <= nxt;
		end
	end

	assign dout = stage_q;
endmodule
`default_nettype wire

// ===== rtl/ip_address_alu.sv =====
// Usage notes
// IPv4/IPv6 address ALU. One item in, one result item out, in order.
// Input channel s_*: tuser {b_is_v6, a_is_v6, kind}, tdata {b_lo, b_hi, a_lo, a_hi}.
// Output channel m_*: tuser {res_is_v6},
//   tdata {pad, error, value, is_greater, is_less, is_equal, res_lo, res_hi}.
// Throughput: one item per cycle while the output is not stalled.
// Pipeline: input register, 32 remainder stages of 4 dividend bits each,
// output register; the remainder chain sets its depth.
// All operations pass through the same number of registers so results stay in order.
// Reset clears every valid bit; no item is in flight afterwards.
// When m_tready is low with a result waiting, the whole pipeline holds and
// s_tready drops; nothing is lost or repeated.
`default_nettype none
module ip_address_alu (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	input  wire logic [255:0] s_tdata,  // a_hi, a_lo, b_hi, b_lo
	input  wire logic [4:0]   s_tuser,  // kind[2:0], a_is_v6, b_is_v6
	output logic              m_tvalid,
	input  wire logic         m_tready,
	output logic [167:0]      m_tdata,  // res_hi, res_lo, is_equal, is_less, is_greater, value, error, pad
	output logic [0:0]        m_tuser   // res_is_v6
);
	import ipalu_pkg::*;

	localparam int NVal = DivStages + 2;

	logic            en;
	logic [NVal-1:0] vld_q;
	item_t           item_s1;
	item_t           item_d;
	div_t            div_in;
	div_t            div_c [DivStages+1];
	res_t            res_a;
	res_t            res_dly [DivStages-2];
	res_t            out_d;
	res_t            out_s34;
	logic            av6;
	logic            bv6;

	assign en       = !vld_q[NVal-1] || m_tready;
	assign s_tready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[NVal-2:0], s_tvalid};
		end
	end

	always_comb begin
		av6           = s_tuser[3];
		bv6           = s_tuser[4];
		item_d.kind   = kind_t'(s_tuser[2:0]);
		item_d.av6    = av6;
		item_d.bv6    = bv6;
		item_d.a      = av6 ? {s_tdata[63:0], s_tdata[127:64]} : {96'd0, s_tdata[95:64]};
		item_d.b      = bv6 ? {s_tdata[191:128], s_tdata[255:192]} : {96'd0, s_tdata[223:192]};
		item_d.b_raw  = s_tdata[255:192];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			item_s1 <= item_d;
		end
	end

	ipalu_arith u_arith (
		.clk  (clk),
		.en   (en),
		.item (item_s1),
		.res  (res_a)
	);

	assign div_in.rem = '0;
	assign div_in.num = item_s1.a;
	assign div_in.d   = item_s1.b_raw[DivW-1:0];
	assign div_c[0]   = div_in;

	for (genvar g = 0; g < DivStages; g++) begin : g_div
		ipalu_div_stage u_stage (
			.clk  (clk),
			.en   (en),
			.din  (div_c[g]),
			.dout (div_c[g+1])
		);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_dly[0] <= res_a;
			for (int i = 1; i < DivStages - 2; i++) begin
				res_dly[i] <= res_dly[i-1];
			end
		end
	end

	always_comb begin
		out_d = res_dly[DivStages-3];
		if (out_d.is_mod) begin
			out_d.val = out_d.err ? '0 : div_c[DivStages].rem;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_s34 <= out_d;
		end
	end

	assign m_tvalid = vld_q[NVal-1];
	assign m_tuser  = out_s34.rv6;
	assign m_tdata  = {4'd0, out_s34.err, out_s34.val, out_s34.gt, out_s34.lt,
		out_s34.eq, out_s34.rl, out_s34.rh};
endmodule
`default_nettype wire

// ===== rtl/ipalu_checker.sv =====
// Port-level checker for the IP address ALU, bound to the top level.
`default_nettype none
module ipalu_checker (
	input wire logic         clk,
	input wire logic         arst_n,
	input wire logic         s_tready,
	input wire logic         m_tvalid,
	input wire logic         m_tready,
	input wire logic [167:0] m_tdata,
	input wire logic [0:0]   m_tuser
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("output item changed while stalled");

	a_flags: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> $countones(m_tdata[130:128]) <= 1)
		else $error("more than one compare flag set");

	a_errval: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[163] |-> m_tdata[162:131] == 32'd0)
		else $error("error item with nonzero value");

	a_flow: assert property (@(posedge clk) disable iff (!arst_n)
		m_tready |-> s_tready)
		else $error("input blocked while output drains");
endmodule

bind ip_address_alu ipalu_checker u_ipalu_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
`default_nettype wire
